@@ rtl/assert_macros.svh @@
// Assertion macros shared by the fan curve interpolator RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FCRI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fcri assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FCRI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fcri assertion failed");

`endif

@@ rtl/fcri_pkg.sv @@
// Package for the fan curve interpolator: curve ROM, reciprocal tables,
// widths, register codes and the structs passed between pipeline modules.
package fcri_pkg;

  localparam int CURVE_POINTS = 22;
  localparam int ROM_POINTS   = 22;
  localparam int USED_POINTS  = (CURVE_POINTS > ROM_POINTS) ? ROM_POINTS :
                                ((CURVE_POINTS < 2) ? 2 : CURVE_POINTS);
  localparam int LAST_IDX     = USED_POINTS - 1;

  localparam int DUTY_W = 7;
  localparam int RPM_W  = 11;
  localparam int PCT_W  = 7;
  localparam int IDX_W  = $clog2(ROM_POINTS);

  // Segment numerator rise*off + span/2 stays below 1024 for this curve.
  localparam int NUM_W    = 12;
  // Ceiling reciprocals with a 20-bit shift are exact while num*span < 2^20.
  localparam int RECIP_W  = 20;
  localparam int RECIP_SH = 20;
  localparam int PROD_W   = NUM_W + RECIP_W;

  // Tolerance: (rpm*pct + 50)/100 via a ceiling reciprocal of 100 at 2^25,
  // exact while the dividend times 100 stays below 2^25.
  localparam int TOLX_W       = RPM_W + PCT_W;
  localparam int TOL_RECIP_W  = 19;
  localparam int TOL_SH       = 25;
  localparam int TOLP_W       = TOLX_W + TOL_RECIP_W;
  localparam logic [TOL_RECIP_W-1:0] TOL_RECIP  = 19'd335545;
  localparam logic [TOLX_W-1:0]      ROUND_BIAS = 18'd50;

  localparam logic [PCT_W-1:0]  TOL_PCT_RST  = 7'd10;
  localparam logic [DUTY_W-1:0] MIN_DUTY_RST = 7'd20;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [DUTY_W-1:0] ROM_DUTY [ROM_POINTS] = '{
    7'd0,  7'd5,  7'd10, 7'd12, 7'd17, 7'd22, 7'd27, 7'd32, 7'd37, 7'd42, 7'd47,
    7'd52, 7'd57, 7'd62, 7'd67, 7'd72, 7'd77, 7'd82, 7'd87, 7'd92, 7'd97, 7'd100
  };

  localparam logic [RPM_W-1:0] ROM_RPM [ROM_POINTS] = '{
    11'd0,   11'd0,   11'd150,  11'd187,  11'd277,  11'd352,  11'd435,  11'd517,
    11'd570, 11'd637, 11'd697,  11'd765,  11'd832,  11'd885,  11'd930,  11'd997,
    11'd1050, 11'd1102, 11'd1147, 11'd1185, 11'd1230, 11'd1252
  };

  // Ceiling of 2^RECIP_SH over the span ending at each point; entry 0 has no span.
  localparam logic [RECIP_W-1:0] SEG_RECIP [ROM_POINTS] = '{
    20'd0,      20'd209716, 20'd209716, 20'd524288, 20'd209716, 20'd209716,
    20'd209716, 20'd209716, 20'd209716, 20'd209716, 20'd209716, 20'd209716,
    20'd209716, 20'd209716, 20'd209716, 20'd209716, 20'd209716, 20'd209716,
    20'd209716, 20'd209716, 20'd209716, 20'd349526
  };

  typedef enum logic [1:0] {
    MODE_LOW    = 2'd0,
    MODE_HIGH   = 2'd1,
    MODE_INTERP = 2'd2
  } mode_t;

  typedef enum logic {
    REG_TOL_PCT  = 1'b0,
    REG_MIN_DUTY = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [PCT_W-1:0]  tol_pct;
    logic [DUTY_W-1:0] min_duty;
  } cfg_t;

  typedef struct packed {
    mode_t             mode;
    logic [IDX_W-1:0]  idx;
    logic [NUM_W-1:0]  num;
    logic              chk;
  } num_stage_t;

  typedef struct packed {
    logic [RPM_W-1:0] rpm;
    logic             chk;
  } rpm_stage_t;

endpackage

@@ rtl/fcri_seg_search.sv @@
// Segment search and numerator stages of the fan curve interpolator.
// Depends on fcri_pkg for the curve ROM, widths and stage structs.
module fcri_seg_search (
  input  logic                             clk,
  input  logic                             rst_n,
  input  fcri_pkg::cfg_t                   cfg,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [fcri_pkg::DUTY_W-1:0]      in_duty,
  output logic                             out_valid,
  input  logic                             out_ready,
  output fcri_pkg::num_stage_t             out_data
);

  logic                              va_r;
  fcri_pkg::mode_t                   a_mode_r, a_mode_nxt;
  logic [fcri_pkg::IDX_W-1:0]        a_idx_r, a_idx_nxt;
  logic [fcri_pkg::DUTY_W-1:0]       a_duty_r;
  logic                              a_chk_r, a_chk_nxt;
  logic                              found;

  logic                              vb_r;
  fcri_pkg::num_stage_t              b_r, b_nxt;
  logic [fcri_pkg::IDX_W-1:0]        lo_idx;
  logic [fcri_pkg::DUTY_W-1:0]       off;
  logic [fcri_pkg::DUTY_W-1:0]       half;
  logic [fcri_pkg::RPM_W-1:0]        rise;
  logic [fcri_pkg::RPM_W+fcri_pkg::DUTY_W-1:0] rise_off;

  logic rdy_a, rdy_b;

  assign rdy_b    = !vb_r || out_ready;
  assign rdy_a    = !va_r || rdy_b;
  assign in_ready = rdy_a;

  // Stage A: clamp test and first curve point at or above the duty.
  always_comb begin
    a_mode_nxt = fcri_pkg::MODE_INTERP;
    a_idx_nxt  = fcri_pkg::IDX_W'(fcri_pkg::LAST_IDX);
    a_chk_nxt  = (in_duty >= cfg.min_duty);
    found      = 1'b0;
    if (in_duty <= fcri_pkg::ROM_DUTY[0]) begin
      a_mode_nxt = fcri_pkg::MODE_LOW;
    end else if (in_duty >= fcri_pkg::ROM_DUTY[fcri_pkg::LAST_IDX]) begin
      a_mode_nxt = fcri_pkg::MODE_HIGH;
    end
    for (int i = 1; i < fcri_pkg::USED_POINTS; i++) begin
      if (!found && (in_duty <= fcri_pkg::ROM_DUTY[i])) begin
        a_idx_nxt = fcri_pkg::IDX_W'(i);
        found     = 1'b1;
      end
    end
  end

  // Stage B: rise*off + span/2 for the chosen segment.
  always_comb begin
    lo_idx     = a_idx_r - 1'b1;
    off        = a_duty_r - fcri_pkg::ROM_DUTY[lo_idx];
    rise       = fcri_pkg::ROM_RPM[a_idx_r] - fcri_pkg::ROM_RPM[lo_idx];
    half       = (fcri_pkg::ROM_DUTY[a_idx_r] - fcri_pkg::ROM_DUTY[lo_idx]) >> 1;
    rise_off   = rise * off;
    b_nxt.mode = a_mode_r;
    b_nxt.idx  = a_idx_r;
    b_nxt.num  = fcri_pkg::NUM_W'(rise_off + (fcri_pkg::RPM_W + fcri_pkg::DUTY_W)'(half));
    b_nxt.chk  = a_chk_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (rdy_a) va_r <= in_valid;
      if (rdy_b) vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_a && in_valid) begin
      a_mode_r <= a_mode_nxt;
      a_idx_r  <= a_idx_nxt;
      a_duty_r <= in_duty;
      a_chk_r  <= a_chk_nxt;
    end
    if (rdy_b && va_r) begin
      b_r <= b_nxt;
    end
  end

  assign out_valid = vb_r;
  assign out_data  = b_r;

endmodule

@@ rtl/fcri_interp.sv @@
// Reciprocal divide and segment offset stages of the fan curve interpolator.
// Depends on fcri_pkg for the reciprocal table, curve ROM and stage structs.
module fcri_interp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  fcri_pkg::num_stage_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output fcri_pkg::rpm_stage_t  out_data
);

  logic                          vc_r;
  fcri_pkg::mode_t               c_mode_r;
  logic [fcri_pkg::IDX_W-1:0]    c_idx_r;
  logic [fcri_pkg::PROD_W-1:0]   c_prod_r, c_prod_nxt;
  logic                          c_chk_r;

  logic                          vd_r;
  fcri_pkg::rpm_stage_t          d_r, d_nxt;
  logic [fcri_pkg::IDX_W-1:0]    lo_idx;
  logic [fcri_pkg::RPM_W-1:0]    quot;

  logic rdy_c, rdy_d;

  assign rdy_d    = !vd_r || out_ready;
  assign rdy_c    = !vc_r || rdy_d;
  assign in_ready = rdy_c;

  // Stage C: multiply by the segment's reciprocal to divide by its span.
  assign c_prod_nxt = in_data.num * fcri_pkg::SEG_RECIP[in_data.idx];

  // Stage D: add the quotient to the segment's lower speed, or clamp.
  always_comb begin
    lo_idx    = c_idx_r - 1'b1;
    quot      = c_prod_r[fcri_pkg::RECIP_SH +: fcri_pkg::RPM_W];
    d_nxt.chk = c_chk_r;
    case (c_mode_r)
      fcri_pkg::MODE_LOW:    d_nxt.rpm = fcri_pkg::ROM_RPM[0];
      fcri_pkg::MODE_HIGH:   d_nxt.rpm = fcri_pkg::ROM_RPM[fcri_pkg::LAST_IDX];
      fcri_pkg::MODE_INTERP: d_nxt.rpm = fcri_pkg::ROM_RPM[lo_idx] + quot;
      default:               d_nxt.rpm = fcri_pkg::ROM_RPM[fcri_pkg::LAST_IDX];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (rdy_c) vc_r <= in_valid;
      if (rdy_d) vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_c && in_valid) begin
      c_mode_r <= in_data.mode;
      c_idx_r  <= in_data.idx;
      c_prod_r <= c_prod_nxt;
      c_chk_r  <= in_data.chk;
    end
    if (rdy_d && vc_r) begin
      d_r <= d_nxt;
    end
  end

  assign out_valid = vd_r;
  assign out_data  = d_r;

endmodule

@@ rtl/fcri_tol.sv @@
// Tolerance band stages and output register of the fan curve interpolator.
// Depends on fcri_pkg for the reciprocal of 100, widths and stage structs.
module fcri_tol (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fcri_pkg::cfg_t                cfg,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  fcri_pkg::rpm_stage_t          in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [fcri_pkg::RPM_W-1:0]    out_rpm,
  output logic [fcri_pkg::RPM_W-1:0]    out_tol,
  output logic                          out_chk
);

  logic                          ve_r;
  fcri_pkg::rpm_stage_t          e_r;
  logic [fcri_pkg::TOLX_W-1:0]   e_x_r, e_x_nxt;

  logic                          vf_r;
  fcri_pkg::rpm_stage_t          f_r;
  logic [fcri_pkg::TOLP_W-1:0]   f_p_r, f_p_nxt;

  logic                          vg_r;
  logic [fcri_pkg::RPM_W-1:0]    g_rpm_r;
  logic [fcri_pkg::RPM_W-1:0]    g_tol_r, g_tol_nxt;
  logic                          g_chk_r;

  logic rdy_e, rdy_f, rdy_g;

  assign rdy_g    = !vg_r || out_ready;
  assign rdy_f    = !vf_r || rdy_g;
  assign rdy_e    = !ve_r || rdy_f;
  assign in_ready = rdy_e;

  assign e_x_nxt   = in_data.rpm * cfg.tol_pct + fcri_pkg::ROUND_BIAS;
  assign f_p_nxt   = e_x_r * fcri_pkg::TOL_RECIP;
  // The divide by 100 is the high part of the reciprocal product.
  assign g_tol_nxt = (f_r.rpm == '0) ? '0 : f_p_r[fcri_pkg::TOL_SH +: fcri_pkg::RPM_W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
      vf_r <= 1'b0;
      vg_r <= 1'b0;
    end else begin
      if (rdy_e) ve_r <= in_valid;
      if (rdy_f) vf_r <= ve_r;
      if (rdy_g) vg_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_e && in_valid) begin
      e_r   <= in_data;
      e_x_r <= e_x_nxt;
    end
    if (rdy_f && ve_r) begin
      f_r   <= e_r;
      f_p_r <= f_p_nxt;
    end
    if (rdy_g && vf_r) begin
      g_rpm_r <= f_r.rpm;
      g_tol_r <= g_tol_nxt;
      g_chk_r <= f_r.chk;
    end
  end

  assign out_valid = vg_r;
  assign out_rpm   = g_rpm_r;
  assign out_tol   = g_tol_r;
  assign out_chk   = g_chk_r;

endmodule

@@ rtl/fan_curve_rpm_interpolator_core.sv @@
// Top level of the fan curve interpolator: configuration registers and the
// seven-stage pipeline. Depends on fcri_pkg, fcri_seg_search, fcri_interp,
// fcri_tol and assert_macros.svh.
//
//   channel  direction  transfer when                        carries
//   in_      slave      in_tvalid & in_tready                duty_percent
//   out_     master     out_tvalid & out_tready              rpm, tolerance, check flag
//   cfg_     APB slave  psel & penable & pwrite & pready     two 7-bit registers
//
// One duty per cycle is taken unless a full pipeline is held by out_tready; each result passes
// through segment search, numerator, span reciprocal, offset add, tolerance product,
// reciprocal of 100 and the output register.
// Reset is synchronous on rst_n: valid bits clear and the registers return to
// 10 percent tolerance and a threshold of 20 percent duty.
// Each stage holds while the one after it is full, so bubbles close up and
// in_tready follows out_tready combinationally only when every stage is full.
`include "assert_macros.svh"

module fan_curve_rpm_interpolator_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [7:0]                        in_tdata,   // [6:0] duty_percent, [7] pad
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [23:0]                       out_tdata,  // [10:0] expected_rpm,
                                                        // [21:11] tolerance_rpm, [23:22] pad
  output logic                              out_tuser,  // [0] in_check_region
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [fcri_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [fcri_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [fcri_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  fcri_pkg::cfg_t               cfg_r;
  fcri_pkg::reg_idx_t           reg_sel;
  logic                         wr_en;

  logic                         s_valid, s_ready;
  fcri_pkg::num_stage_t         s_data;
  logic                         i_valid, i_ready;
  fcri_pkg::rpm_stage_t         i_data;
  logic [fcri_pkg::RPM_W-1:0]   rpm_o, tol_o;
  logic                         chk_o;

  assign cfg_pready = 1'b1;
  assign reg_sel    = fcri_pkg::reg_idx_t'(cfg_paddr[2]);
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tol_pct  <= fcri_pkg::TOL_PCT_RST;
      cfg_r.min_duty <= fcri_pkg::MIN_DUTY_RST;
    end else if (wr_en) begin
      unique case (reg_sel)
        fcri_pkg::REG_TOL_PCT:  cfg_r.tol_pct  <= cfg_pwdata[fcri_pkg::PCT_W-1:0];
        fcri_pkg::REG_MIN_DUTY: cfg_r.min_duty <= cfg_pwdata[fcri_pkg::DUTY_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      fcri_pkg::REG_TOL_PCT:  cfg_prdata = fcri_pkg::CFG_DATA_W'(cfg_r.tol_pct);
      fcri_pkg::REG_MIN_DUTY: cfg_prdata = fcri_pkg::CFG_DATA_W'(cfg_r.min_duty);
    endcase
  end

  fcri_seg_search u_seg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_duty   (in_tdata[fcri_pkg::DUTY_W-1:0]),
    .out_valid (s_valid),
    .out_ready (s_ready),
    .out_data  (s_data)
  );

  fcri_interp u_interp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s_valid),
    .in_ready  (s_ready),
    .in_data   (s_data),
    .out_valid (i_valid),
    .out_ready (i_ready),
    .out_data  (i_data)
  );

  fcri_tol u_tol (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (i_valid),
    .in_ready  (i_ready),
    .in_data   (i_data),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_rpm   (rpm_o),
    .out_tol   (tol_o),
    .out_chk   (chk_o)
  );

  assign out_tdata = {2'b00, tol_o, rpm_o};
  assign out_tuser = chk_o;

  // With the output stage empty the whole ready chain must be open.
  `FCRI_ASSERT_IMPL(a_idle_ready, clk, rst_n, !out_tvalid, in_tready)
  `FCRI_ASSERT_IMPL(a_zero_tol, clk, rst_n, out_tvalid && (rpm_o == '0), tol_o == '0)
  `FCRI_ASSERT_IMPL(a_rpm_range, clk, rst_n, out_tvalid, rpm_o <= fcri_pkg::ROM_RPM[fcri_pkg::LAST_IDX])
  `FCRI_ASSERT_NEXT(a_tol_write, clk, rst_n, wr_en && (reg_sel == fcri_pkg::REG_TOL_PCT), cfg_r.tol_pct == $past(cfg_pwdata[fcri_pkg::PCT_W-1:0]))

endmodule
